### hw/rtl/ocpg_pkg.sv
`timescale 1ns / 1ps

package ocpg_pkg;

  localparam int COORD_W   = 16;
  localparam int Z_W       = 16;
  localparam int RAD_W     = 12;
  localparam int RR_W      = 2 * RAD_W;
  localparam int OCT_W     = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NSLOT     = 8;
  localparam int SLOT_W    = 3;
  localparam int ITER_W    = $clog2(RAD_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_CENTER_Z  = 3'd2,
    CFG_RADIUS    = 3'd3,
    CFG_FIRST_OCT = 3'd4,
    CFG_LAST_OCT  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_AXIS,
    MODE_COLUMN,
    MODE_DIAG
  } mode_t;

endpackage

### hw/rtl/octant_circle_point_generator_core.sv
`timescale 1ns / 1ps

// Circle point generator over an octant range. Each accepted item is one tick: restart
// emits the axis points, later ticks emit one mirrored column each, and a final tick,
// when the columns reach the diagonal, the diagonal points. A restart or column tick
// runs the squaring states ST_MUL_R and ST_MUL_X, the subtract state ST_SUB, the shared
// square-root state ST_ROOT and the rounding state ST_ROUND. It then steps through the
// slots up to the last enabled one: up to 8 for a column and up to 4 for axis. Each point
// waits while out_stall is high. A diagonal tick skips the root and steps through up to
// 4 slots. A tick with no circle active emits nothing.
module octant_circle_point_generator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ocpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ocpg_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ocpg_pkg::COORD_W-1:0] out_point_x,
  output logic signed [ocpg_pkg::COORD_W-1:0] out_point_y,
  output logic signed [ocpg_pkg::Z_W-1:0]   out_point_z,
  output logic [ocpg_pkg::OCT_W-1:0]        out_octant_label,
  output logic                              out_last_of_step,
  output logic                              out_circle_done
);
  import ocpg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_R,
    ST_MUL_X,
    ST_SUB,
    ST_ROOT,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_DONE   = 2'd0,
    PH_COLUMN = 2'd1,
    PH_DIAG   = 2'd2
  } phase_t;

  state_t                    state_r;
  phase_t                    phase_r;
  mode_t                     mode_r;
  logic signed [COORD_W-1:0] cx_r;
  logic signed [COORD_W-1:0] cy_r;
  logic signed [Z_W-1:0]     cz_r;
  logic [RAD_W-1:0]          rad_r;
  logic [OCT_W-1:0]          first_oct_r;
  logic [OCT_W-1:0]          last_oct_r;
  logic [RAD_W-1:0]          mx_r;
  logic [RAD_W-1:0]          my_r;
  logic [RAD_W-1:0]          a_r;
  logic [RAD_W-1:0]          b_r;
  logic [NSLOT-1:0]          mask_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [SLOT_W-1:0]         last_slot_r;
  logic [RR_W-1:0]           rem_r;
  logic [RR_W-1:0]           prod_r;
  logic [RR_W-1:0]           res_r;
  logic [RR_W-1:0]           bit_r;
  logic [ITER_W-1:0]         iter_r;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r;
  logic signed [COORD_W-1:0] out_y_r;
  logic signed [Z_W-1:0]     out_z_r;
  logic [OCT_W-1:0]          out_oct_r;
  logic                      out_last_r;
  logic                      out_done_r;

  logic [OCT_W-1:0]          s_oct;
  logic [OCT_W-1:0]          e_oct;
  logic [NSLOT-1:0]          axis_mask;
  logic [NSLOT-1:0]          col_mask;
  logic [NSLOT-1:0]          diag_mask;
  logic [NSLOT-1:0]          acc_mask;
  logic [SLOT_W-1:0]         acc_last;
  logic [RR_W:0]             trial;
  logic [RAD_W-1:0]          my_nxt;
  logic [RAD_W-1:0]          sq_op;
  logic [RR_W-1:0]           sq_val;
  logic signed [RAD_W:0]     pa;
  logic signed [RAD_W:0]     na;
  logic signed [RAD_W:0]     pb;
  logic signed [RAD_W:0]     nb;
  logic signed [RAD_W:0]     dx;
  logic signed [RAD_W:0]     dy;
  logic [OCT_W-1:0]          oct;
  logic                      out_free;
  logic                      slot_on;
  logic                      emit_go;

  assign s_oct = first_oct_r;
  assign e_oct = (last_oct_r < first_oct_r) ? first_oct_r : last_oct_r;

  always_comb begin
    axis_mask    = '0;
    axis_mask[0] = (s_oct <= 3'd4) && (e_oct >= 3'd3);
    axis_mask[1] = (s_oct == 3'd0) || (e_oct == 3'd7);
    axis_mask[2] = (s_oct <= 3'd2) && (e_oct >= 3'd1);
    axis_mask[3] = (s_oct <= 3'd6) && (e_oct >= 3'd5);
    diag_mask    = '0;
    diag_mask[0] = (s_oct <= 3'd3) && (e_oct >= 3'd2);
    diag_mask[1] = (s_oct <= 3'd1);
    diag_mask[2] = (s_oct <= 3'd5) && (e_oct >= 3'd4);
    diag_mask[3] = (e_oct >= 3'd6);
    for (int k = 0; k < NSLOT; k++) begin
      col_mask[k] = (SLOT_W'(k) >= s_oct) && (SLOT_W'(k) <= e_oct);
    end
  end

  always_comb begin
    if (in_restart) begin
      acc_mask = axis_mask;
    end else if (phase_r == PH_COLUMN) begin
      acc_mask = col_mask;
    end else begin
      acc_mask = diag_mask;
    end
    acc_last = '0;
    for (int k = 0; k < NSLOT; k++) begin
      if (acc_mask[k]) begin
        acc_last = SLOT_W'(k);
      end
    end
  end

  assign trial  = {1'b0, res_r} + {1'b0, bit_r};
  assign my_nxt = RAD_W'(res_r + ((rem_r > res_r) ? RR_W'(1) : RR_W'(0)));
  assign sq_op  = (state_r == ST_MUL_R) ? rad_r : mx_r;
  assign sq_val = RR_W'(sq_op) * RR_W'(sq_op);

  always_comb begin
    pa = $signed({1'b0, a_r});
    na = -pa;
    pb = $signed({1'b0, b_r});
    nb = -pb;
    dx = '0;
    dy = '0;
    oct = slot_r;
    case (mode_r)
      MODE_AXIS: begin
        case (slot_r)
          3'd0: begin dy = pa; oct = 3'd4; end
          3'd1: begin dy = na; oct = 3'd0; end
          3'd2: begin dx = pa; oct = 3'd2; end
          default: begin dx = na; oct = 3'd6; end
        endcase
      end
      MODE_COLUMN: begin
        case (slot_r)
          3'd0: begin dx = pa; dy = nb; end
          3'd1: begin dx = pb; dy = na; end
          3'd2: begin dx = pb; dy = pa; end
          3'd3: begin dx = pa; dy = pb; end
          3'd4: begin dx = na; dy = pb; end
          3'd5: begin dx = nb; dy = pa; end
          3'd6: begin dx = nb; dy = na; end
          default: begin dx = na; dy = nb; end
        endcase
      end
      default: begin
        case (slot_r)
          3'd0: begin dx = pa; dy = pa; oct = 3'd3; end
          3'd1: begin dx = pa; dy = na; oct = 3'd1; end
          3'd2: begin dx = na; dy = pa; oct = 3'd5; end
          default: begin dx = na; dy = na; oct = 3'd7; end
        endcase
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign slot_on  = mask_r[slot_r];
  assign emit_go  = (state_r == ST_EMIT) && slot_on && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_DONE;
      mx_r        <= RAD_W'(1);
      my_r        <= '0;
      out_valid_r <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
      cz_r        <= '0;
      rad_r       <= RAD_W'(1);
      first_oct_r <= '0;
      last_oct_r  <= 3'd7;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X:  cx_r        <= cfg_wdata[COORD_W-1:0];
          CFG_CENTER_Y:  cy_r        <= cfg_wdata[COORD_W-1:0];
          CFG_CENTER_Z:  cz_r        <= cfg_wdata[Z_W-1:0];
          CFG_RADIUS:    rad_r       <= cfg_wdata[RAD_W-1:0];
          CFG_FIRST_OCT: first_oct_r <= cfg_wdata[OCT_W-1:0];
          CFG_LAST_OCT:  last_oct_r  <= cfg_wdata[OCT_W-1:0];
          default: ;
        endcase
      end

      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mask_r      <= acc_mask;
            last_slot_r <= acc_last;
            slot_r      <= '0;
            if (in_restart) begin
              mode_r  <= MODE_AXIS;
              a_r     <= rad_r;
              mx_r    <= RAD_W'(1);
              state_r <= ST_MUL_R;
            end else begin
              case (phase_r)
                PH_COLUMN: begin
                  mode_r  <= MODE_COLUMN;
                  a_r     <= mx_r;
                  b_r     <= my_r;
                  mx_r    <= mx_r + RAD_W'(1);
                  state_r <= ST_MUL_R;
                end
                PH_DIAG: begin
                  mode_r  <= MODE_DIAG;
                  a_r     <= mx_r;
                  phase_r <= PH_DONE;
                  state_r <= ST_EMIT;
                end
                default: phase_r <= PH_DONE;
              endcase
            end
          end
        end
        ST_MUL_R: begin
          rem_r   <= sq_val;
          state_r <= ST_MUL_X;
        end
        ST_MUL_X: begin
          prod_r  <= sq_val;
          state_r <= ST_SUB;
        end
        ST_SUB: begin
          rem_r   <= (rem_r > prod_r) ? (rem_r - prod_r) : '0;
          res_r   <= '0;
          bit_r   <= RR_W'(1) << (RR_W - 2);
          iter_r  <= ITER_W'(RAD_W - 1);
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if ({1'b0, rem_r} >= trial) begin
            rem_r <= rem_r - trial[RR_W-1:0];
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (iter_r == '0) begin
            state_r <= ST_ROUND;
          end else begin
            iter_r <= iter_r - ITER_W'(1);
          end
        end
        ST_ROUND: begin
          my_r <= my_nxt;
          if (mx_r < my_nxt) begin
            phase_r <= PH_COLUMN;
          end else if (mx_r == my_nxt) begin
            phase_r <= PH_DIAG;
          end else begin
            phase_r <= PH_DONE;
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!slot_on || out_free) begin
            if (slot_on) begin
              out_x_r     <= cx_r + COORD_W'(dx);
              out_y_r     <= cy_r + COORD_W'(dy);
              out_z_r     <= cz_r;
              out_oct_r   <= oct;
              out_last_r  <= (slot_r == last_slot_r);
              out_done_r  <= (slot_r == last_slot_r) && (phase_r == PH_DONE);
            end
            if (slot_r == last_slot_r) begin
              state_r <= ST_IDLE;
            end else begin
              slot_r <= slot_r + SLOT_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_point_x      = out_x_r;
  assign out_point_y      = out_y_r;
  assign out_point_z      = out_z_r;
  assign out_octant_label = out_oct_r;
  assign out_last_of_step = out_last_r;
  assign out_circle_done  = out_done_r;

endmodule
